### design/aes_block_cipher_engine_unit_defines.svh
`ifndef AES_BLOCK_CIPHER_ENGINE_UNIT_DEFINES_SVH
`define AES_BLOCK_CIPHER_ENGINE_UNIT_DEFINES_SVH
// Assertion helpers
`define AES_ASSERT_IMPL(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("%m: lbl failed");
`define AES_ASSERT_NEXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("%m: lbl failed");
`endif

### design/aes_pkg.sv
package aes_pkg;

  typedef enum logic [2:0] {
    CFG_KEY_SIZE = 3'd0,
    CFG_KEY_P0   = 3'd1,
    CFG_KEY_P1   = 3'd2,
    CFG_KEY_P2   = 3'd3,
    CFG_KEY_P3   = 3'd4
  } cfg_idx_t;

  localparam logic [1:0] KS_128 = 2'd0;
  localparam logic [1:0] KS_192 = 2'd1;
  localparam logic [1:0] KS_256 = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXPAND = 5'b00010,
    ST_INIT   = 5'b00100,
    ST_ROUND  = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] inv_sbox(input logic [7:0] v);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 256; i++) begin
      if (SBOX[i] == v) r = 8'(i);
    end
    return r;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    return {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
            a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
            a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
            xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
  endfunction

  function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] o [4];
    for (int k = 0; k < 4; k++) begin
      a[k] = c[31-8*k -: 8];
      x2[k] = xt(a[k]);
      x4[k] = xt(x2[k]);
      x8[k] = xt(x4[k]);
    end
    for (int r = 0; r < 4; r++) begin
      o[r] = (x8[r] ^ x4[r] ^ x2[r])
           ^ (x8[(r+1)%4] ^ x2[(r+1)%4] ^ a[(r+1)%4])
           ^ (x8[(r+2)%4] ^ x4[(r+2)%4] ^ a[(r+2)%4])
           ^ (x8[(r+3)%4] ^ a[(r+3)%4]);
    end
    return {o[0], o[1], o[2], o[3]};
  endfunction

endpackage

### design/aes_block_cipher_engine_unit.sv
// AES-128/192/256 engine. Write key_size and key parts on the cfg channel while idle and no
// request is offered; any write to key_size or a key part forces a key re-expansion before
// the next request, one schedule word per cycle. A request is taken when start is high and
// busy is low. One shared round unit does one round per cycle; busy stays high through
// any expansion, the initial key addition, the rounds and the done state. The result is
// shown for exactly one cycle with out_valid right after busy drops, and a new request can
// be taken in that cycle; no request is taken while one is still in progress.
// The receiver cannot stall.
`include "aes_block_cipher_engine_unit_defines.svh"
module aes_block_cipher_engine_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_kind,
  input  logic [63:0] in_block_hi,
  input  logic [63:0] in_block_lo,
  output logic        out_valid,
  output logic [63:0] out_result_hi,
  output logic [63:0] out_result_lo,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  aes_pkg::state_t state_r, state_nxt;
  logic [1:0]   key_size_r;
  logic [255:0] key_r;
  logic         keys_valid_r;
  logic         kind_r;
  logic [127:0] st_r;
  logic [5:0]   wi_r;
  logic [3:0]   rnd_r;
  logic [2:0]   rc_pos_r;
  logic [7:0]   rc_r;
  logic [255:0] win_r;
  logic [127:0] rk_mem [16];
  logic [127:0] rk_q_r;
  logic [3:0]   rd_addr;
  logic         out_valid_r;

  logic [3:0] nk, nr;
  logic [5:0] total;
  always_comb begin
    unique case (key_size_r)
      aes_pkg::KS_128: begin nk = 4'd4; nr = 4'd10; total = 6'd44; end
      aes_pkg::KS_192: begin nk = 4'd6; nr = 4'd12; total = 6'd52; end
      default:         begin nk = 4'd8; nr = 4'd14; total = 6'd60; end
    endcase
  end

  assign cfg_ready = (state_r == aes_pkg::ST_IDLE) && !start;
  assign busy = (state_r != aes_pkg::ST_IDLE);

  // key schedule word generator: win_r holds the last nk words, newest in [31:0]
  logic [31:0] w_prev, w_back, t, w_new;
  always_comb begin
    w_prev = win_r[31:0];
    w_back = win_r[32*nk-1 -: 32];
    t = w_prev;
    if (rc_pos_r == 3'd0) t = aes_pkg::sbox_word({w_prev[23:0], w_prev[31:24]}) ^ {rc_r, 24'h0};
    else if (nk == 4'd8 && rc_pos_r == 3'd4) t = aes_pkg::sbox_word(w_prev);
    w_new = (wi_r < 6'(nk)) ? key_r[255 - 32*wi_r[2:0] -: 32] : (w_back ^ t);
  end

  // round key read: one 128-bit round key entry per cycle
  logic [3:0] rnd_next;
  always_comb begin
    rnd_next = rnd_r;
    if (state_r == aes_pkg::ST_IDLE) rnd_next = in_kind ? nr : 4'd0;
    else if (state_r == aes_pkg::ST_EXPAND) rnd_next = kind_r ? nr : 4'd0;
    else if (state_r == aes_pkg::ST_INIT) rnd_next = kind_r ? nr - 4'd1 : 4'd1;
    else if (state_r == aes_pkg::ST_ROUND) rnd_next = kind_r ? rnd_r - 4'd1 : rnd_r + 4'd1;
    rd_addr = rnd_next;
  end

  always_ff @(posedge clk) begin
    if (state_r == aes_pkg::ST_EXPAND && wi_r < total)
      rk_mem[wi_r[5:2]][127 - 32*wi_r[1:0] -: 32] <= w_new;
    rk_q_r <= rk_mem[rd_addr];
  end

  // round unit
  logic [127:0] sb, sr, mx, rin, rout;
  logic last;
  always_comb begin
    last = kind_r ? (rnd_r == 4'd0) : (rnd_r == nr);
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr[127 - 8*(r+4*c) -: 8] =
          st_r[127 - 8*(r + 4*(kind_r ? ((c+4-r)%4) : ((c+r)%4))) -: 8];
      end
    end
    for (int i = 0; i < 16; i++) begin
      sb[127-8*i -: 8] = kind_r ? aes_pkg::inv_sbox(sr[127-8*i -: 8])
                                : aes_pkg::SBOX[sr[127-8*i -: 8]];
    end
    for (int c = 0; c < 4; c++) begin
      mx[127-32*c -: 32] = aes_pkg::mix_col(sb[127-32*c -: 32]);
    end
    rin = kind_r ? (sb ^ rk_q_r) : (last ? sb : mx) ^ rk_q_r;
    for (int c = 0; c < 4; c++) begin
      rout[127-32*c -: 32] = (kind_r && !last) ? aes_pkg::inv_mix_col(rin[127-32*c -: 32])
                                               : rin[127-32*c -: 32];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      aes_pkg::ST_IDLE:   if (start) state_nxt = keys_valid_r ? aes_pkg::ST_INIT
                                                              : aes_pkg::ST_EXPAND;
      aes_pkg::ST_EXPAND: if (wi_r == total) state_nxt = aes_pkg::ST_INIT;
      aes_pkg::ST_INIT:   state_nxt = aes_pkg::ST_ROUND;
      aes_pkg::ST_ROUND:  if (last) state_nxt = aes_pkg::ST_DONE;
      aes_pkg::ST_DONE:   state_nxt = aes_pkg::ST_IDLE;
      default:            state_nxt = aes_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aes_pkg::ST_IDLE;
      key_size_r <= aes_pkg::KS_128;
      key_r <= '0;
      keys_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      rnd_r <= '0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= (state_r == aes_pkg::ST_DONE);
      rnd_r <= rnd_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          aes_pkg::CFG_KEY_SIZE: key_size_r <= (cfg_data[1:0] == 2'd3) ? aes_pkg::KS_256
                                                                       : cfg_data[1:0];
          aes_pkg::CFG_KEY_P0: key_r[255:192] <= cfg_data;
          aes_pkg::CFG_KEY_P1: key_r[191:128] <= cfg_data;
          aes_pkg::CFG_KEY_P2: key_r[127:64]  <= cfg_data;
          aes_pkg::CFG_KEY_P3: key_r[63:0]    <= cfg_data;
          default: ;
        endcase
        if (cfg_index <= aes_pkg::CFG_KEY_P3) keys_valid_r <= 1'b0;
      end
      if (state_r == aes_pkg::ST_EXPAND && wi_r == total) keys_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == aes_pkg::ST_IDLE && start) begin
      kind_r <= in_kind;
      st_r <= {in_block_hi, in_block_lo};
      wi_r <= '0;
      rc_pos_r <= '0;
      rc_r <= 8'h01;
    end
    if (state_r == aes_pkg::ST_EXPAND) begin
      wi_r <= wi_r + 6'd1;
      win_r <= {win_r[223:0], w_new};
      if (wi_r >= 6'(nk) && rc_pos_r == 3'd0) rc_r <= aes_pkg::xt(rc_r);
      rc_pos_r <= (rc_pos_r == 3'(nk - 4'd1)) ? 3'd0 : rc_pos_r + 3'd1;
    end
    if (state_r == aes_pkg::ST_INIT) st_r <= st_r ^ rk_q_r;
    if (state_r == aes_pkg::ST_ROUND) st_r <= rout;
  end

  assign out_valid = out_valid_r;
  assign out_result_hi = st_r[127:64];
  assign out_result_lo = st_r[63:0];

  `AES_ASSERT_IMPL(a_busy_cfg, clk, rst_n, busy, !cfg_ready)
  `AES_ASSERT_NEXT(a_done_out, clk, rst_n, state_r == aes_pkg::ST_DONE, out_valid)
  `AES_ASSERT_IMPL(a_out_idle, clk, rst_n, out_valid, state_r == aes_pkg::ST_IDLE)

endmodule

### tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_kind = 1'b0;
  logic [63:0] in_block_hi = '0;
  logic [63:0] in_block_lo = '0;
  logic        out_valid;
  logic [63:0] out_result_hi;
  logic [63:0] out_result_lo;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  aes_block_cipher_engine_unit u_dut (.*);

  always #5 clk = ~clk;

  logic [7:0]  sb [256];
  logic [7:0]  isb [256];
  logic [1:0]  key_size_q;
  logic [63:0] key_q [4];
  logic [31:0] sched [60];
  bit          sched_ok;
  logic [127:0] block_q [$];
  int          errors = 0;
  int          send_gap = 0;

  function automatic logic [7:0] dbl(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = dbl(a);
    end
    return p;
  endfunction

  function automatic int nk_words();
    return key_size_q == aes_pkg::KS_128 ? 4 : (key_size_q == aes_pkg::KS_192 ? 6 : 8);
  endfunction

  task automatic build_schedule();
    int nk;
    logic [7:0] rc;
    logic [31:0] t;
    nk = nk_words();
    rc = 8'h01;
    for (int i = 0; i < nk; i++) sched[i] = key_q[i/2][(i%2) ? 31 : 63 -: 32];
    for (int i = nk; i < 4*(nk+7); i++) begin
      t = sched[i-1];
      if (i % nk == 0) begin
        t = {t[23:0], t[31:24]};
        t = {sb[t[31:24]], sb[t[23:16]], sb[t[15:8]], sb[t[7:0]]} ^ {rc, 24'h0};
        rc = dbl(rc);
      end else if (nk > 6 && i % nk == 4) begin
        t = {sb[t[31:24]], sb[t[23:16]], sb[t[15:8]], sb[t[7:0]]};
      end
      sched[i] = sched[i-nk] ^ t;
    end
    sched_ok = 1;
  endtask

  function automatic void add_rk(ref logic [7:0] s [16], input int rnd);
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) s[r+4*c] ^= sched[4*rnd+c][31-8*r -: 8];
  endfunction

  function automatic void row_shift(ref logic [7:0] s [16], input bit inv);
    logic [7:0] t [16];
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) t[r+4*c] = s[r+4*((inv ? c+4-r : c+r) & 3)];
    s = t;
  endfunction

  function automatic void mix_cols(ref logic [7:0] s [16], input bit inv);
    logic [7:0] m [4];
    logic [7:0] a [4];
    logic [7:0] v;
    if (inv) m = '{8'd14, 8'd11, 8'd13, 8'd9};
    else m = '{8'd2, 8'd3, 8'd1, 8'd1};
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) a[k] = s[k+4*c];
      for (int r = 0; r < 4; r++) begin
        v = 0;
        for (int k = 0; k < 4; k++) v ^= gf_mul(m[(k+4-r) & 3], a[k]);
        s[r+4*c] = v;
      end
    end
  endfunction

  task automatic cipher_block(input bit kind, input logic [127:0] blk,
                              output logic [127:0] res);
    logic [7:0] s [16];
    int nr;
    if (!sched_ok) build_schedule();
    nr = nk_words() + 6;
    for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8];
    if (!kind) begin
      add_rk(s, 0);
      for (int rnd = 1; rnd <= nr; rnd++) begin
        for (int i = 0; i < 16; i++) s[i] = sb[s[i]];
        row_shift(s, 0);
        if (rnd != nr) mix_cols(s, 0);
        add_rk(s, rnd);
      end
    end else begin
      add_rk(s, nr);
      for (int rnd = nr - 1; rnd >= 0; rnd--) begin
        row_shift(s, 1);
        for (int i = 0; i < 16; i++) s[i] = isb[s[i]];
        add_rk(s, rnd);
        if (rnd != 0) mix_cols(s, 1);
      end
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
  endtask

  task automatic send_block(input bit kind, input logic [63:0] hi, input logic [63:0] lo);
    logic [127:0] res;
    while ($urandom_range(99) < send_gap) @(posedge clk);
    start <= 1'b1;
    in_kind <= kind;
    in_block_hi <= hi;
    in_block_lo <= lo;
    do @(posedge clk); while (busy);
    cipher_block(kind, {hi, lo}, res);
    block_q.push_back(res);
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(input aes_pkg::cfg_idx_t idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      aes_pkg::CFG_KEY_SIZE: key_size_q = (val[1:0] == 2'd3) ? aes_pkg::KS_256 : val[1:0];
      aes_pkg::CFG_KEY_P0:   key_q[0] = val;
      aes_pkg::CFG_KEY_P1:   key_q[1] = val;
      aes_pkg::CFG_KEY_P2:   key_q[2] = val;
      aes_pkg::CFG_KEY_P3:   key_q[3] = val;
      default: ;
    endcase
    sched_ok = 0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (block_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic load_key(input logic [1:0] ks, input logic [63:0] k0, input logic [63:0] k1,
                          input logic [63:0] k2, input logic [63:0] k3);
    drain();
    write_reg(aes_pkg::CFG_KEY_SIZE, {62'd0, ks});
    write_reg(aes_pkg::CFG_KEY_P0, k0);
    write_reg(aes_pkg::CFG_KEY_P1, k1);
    write_reg(aes_pkg::CFG_KEY_P2, k2);
    write_reg(aes_pkg::CFG_KEY_P3, k3);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  always @(posedge clk) begin
    logic [127:0] exp_blk;
    if (rst_n && out_valid) begin
      if (block_q.size() == 0) begin
        $display("%0t: unexpected result %h%h", $time, out_result_hi, out_result_lo);
        errors++;
      end else begin
        exp_blk = block_q.pop_front();
        if (out_result_hi !== exp_blk[127:64]) begin
          $display("%0t: result_hi expected %h actual %h", $time, exp_blk[127:64],
                   out_result_hi);
          errors++;
        end
        if (out_result_lo !== exp_blk[63:0]) begin
          $display("%0t: result_lo expected %h actual %h", $time, exp_blk[63:0],
                   out_result_lo);
          errors++;
        end
      end
    end
  end

  task automatic test_reset_key();
    send_block(0, '0, '0);
    send_block(1, '1, '1);
  endtask

  task automatic test_fips_vectors();
    load_key(aes_pkg::KS_128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, rnd64(), rnd64());
    send_block(0, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    load_key(aes_pkg::KS_192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
             64'h1011121314151617, rnd64());
    send_block(0, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(1, '1, '0);
    load_key(2'd3, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617,
             64'h18191a1b1c1d1e1f);
    send_block(0, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
    load_key(aes_pkg::KS_256, '1, '1, '1, '1);
    send_block(0, '1, '1);
    send_block(1, '0, '0);
    drain();
    write_reg(aes_pkg::cfg_idx_t'(3'd7), rnd64());
    write_reg(aes_pkg::cfg_idx_t'(3'd5), rnd64());
    send_block(0, '0, '1);
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0)
        load_key(2'($urandom_range(3)), rnd64(), rnd64(), rnd64(), rnd64());
      send_block($urandom_range(1), rnd64(), rnd64());
    end
  endtask

  initial begin
    for (int i = 0; i < 256; i++) begin
      sb[i] = aes_pkg::SBOX[i];
      isb[aes_pkg::SBOX[i]] = 8'(i);
    end
    key_size_q = aes_pkg::KS_128;
    for (int i = 0; i < 4; i++) key_q[i] = '0;
    sched_ok = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_key();
    test_fips_vectors();
    send_gap = 10;
    test_random(520);
    send_gap = 59;
    test_random(510);
    send_gap = 0;
    test_random(510);
    drain();
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
